// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; pulled in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LCDQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lcdq: check failed");

// Checked on every edge, reset included.
`define LCDQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lcdq: check failed");

`endif

// ===== hw/rtl/lcdq_pkg.sv =====
// Shared types and constants of the character-LCD write queue.
// No dependencies.
package lcdq_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    localparam logic [5:0] MAX_COLUMN  = 6'd40;
    localparam logic [7:0] ADDR_BASE   = 8'h80;
    localparam logic [7:0] ROW2_OFFSET = 8'h40;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] tick_value;
        logic [1:0]  row;
        logic [5:0]  column;
        logic [7:0]  text_byte;
    } item_t;

    typedef struct packed {
        logic       status;
        logic       strobe_res;
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       busy_res;
    } result_t;

endpackage

// ===== hw/rtl/lcdq_in_stage.sv =====
// Input register of the LCD write queue: holds one request for the engine.
// Depends on lcdq_pkg.
module lcdq_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  lcdq_pkg::item_t in_item,
    output logic            hold_valid,
    output lcdq_pkg::item_t hold_item,
    input  logic            take
);

    logic            valid_reg;
    lcdq_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== hw/rtl/lcdq_engine.sv =====
// Queue storage, pacing state and per-request decode of the LCD write queue.
// Depends on lcdq_pkg.
module lcdq_engine #(
    parameter int QUEUE_DEPTH = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  lcdq_pkg::item_t   item,
    output lcdq_pkg::result_t res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic       kind_mem [QUEUE_DEPTH];
    logic [7:0] byte_mem [QUEUE_DEPTH];

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] send_reg, send_next;
    logic [15:0]      nat_reg, nat_next;
    logic             open_reg, open_next;

    // entry at the send position, kept registered
    logic             head_kind_reg;
    logic [7:0]       head_byte_reg;

    logic             push_en;
    logic [IDX_W-1:0] push_idx;
    logic             push_kind;
    logic [7:0]       push_byte;

    logic [IDX_W-1:0] head_idx;
    logic [CNT_W-1:0] send_plus;
    logic [15:0]      tick_diff;
    logic [7:0]       addr_col;
    logic [7:0]       addr;
    logic             pos_bad;

    assign head_idx  = send_next[IDX_W-1:0];
    assign send_plus = send_reg + CNT_W'(1);
    assign tick_diff = item.tick_value - nat_reg;
    assign addr_col  = lcdq_pkg::ADDR_BASE + {2'b00, item.column} - 8'd1;
    assign addr      = (item.row == lcdq_pkg::ROW_SECOND) ?
                       addr_col + lcdq_pkg::ROW2_OFFSET : addr_col;
    assign pos_bad   = (item.row != lcdq_pkg::ROW_FIRST && item.row != lcdq_pkg::ROW_SECOND)
                       || item.column == 6'd0 || item.column > lcdq_pkg::MAX_COLUMN;

    always_comb begin
        fill_next = fill_reg;
        send_next = send_reg;
        nat_next  = nat_reg;
        open_next = open_reg;
        push_en   = 1'b0;
        push_idx  = fill_reg[IDX_W-1:0];
        push_kind = lcdq_pkg::KIND_DATA;
        push_byte = item.text_byte;
        res       = '0;
        case (item.cmd)
            lcdq_pkg::CMD_TICK: begin
                open_next = 1'b0;
                // signed 16-bit compare against the pacing deadline
                if (send_reg < fill_reg && !tick_diff[15]) begin
                    res.strobe_res = 1'b1;
                    res.reg_select = head_kind_reg;
                    res.bus_byte   = head_byte_reg;
                    nat_next       = item.tick_value + 16'd1;
                    if (send_plus >= fill_reg) begin
                        fill_next = '0;
                        send_next = '0;
                    end else begin
                        send_next = send_plus;
                    end
                end
            end
            lcdq_pkg::CMD_START: begin
                if (pos_bad || fill_reg != '0) begin
                    res.status = 1'b1;
                end else begin
                    push_en   = 1'b1;
                    push_idx  = '0;
                    push_kind = lcdq_pkg::KIND_COMMAND;
                    push_byte = addr;
                    fill_next = CNT_W'(1);
                    send_next = '0;
                    open_next = 1'b1;
                end
            end
            lcdq_pkg::CMD_TEXT: begin
                if (!open_reg) begin
                    res.status = 1'b1;
                end else if (item.text_byte == 8'd0) begin
                    open_next = 1'b0;
                end else if (fill_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    res.status = 1'b1;
                    open_next  = 1'b0;
                end else begin
                    push_en   = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            default: begin
                res.status = 1'b1;
            end
        endcase
        res.busy_res = (fill_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            send_reg <= '0;
            nat_reg  <= '0;
            open_reg <= 1'b0;
        end else if (fire) begin
            fill_reg <= fill_next;
            send_reg <= send_next;
            nat_reg  <= nat_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && push_en) begin
            kind_mem[push_idx] <= push_kind;
            byte_mem[push_idx] <= push_byte;
        end
        // head follows the next send position; a push into that slot bypasses the array
        if (fire) begin
            if (push_en && push_idx == head_idx) begin
                head_kind_reg <= push_kind;
                head_byte_reg <= push_byte;
            end else begin
                head_kind_reg <= kind_mem[head_idx];
                head_byte_reg <= byte_mem[head_idx];
            end
        end
    end

endmodule

// ===== hw/rtl/lcdq_out_stage.sv =====
// Result register of the LCD write queue; loads a result as the engine fires.
// Depends on lcdq_pkg.
module lcdq_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lcdq_pkg::result_t load_res,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output lcdq_pkg::result_t out_res
);

    logic              valid_reg;
    lcdq_pkg::result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_paced_write_queue_unit.sv =====
// Top level of the character-LCD paced write queue.
// Depends on lcdq_pkg, lcdq_in_stage, lcdq_engine, lcdq_out_stage.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  s_      | s_valid / s_ready   | s_cmd s_tick_value s_row s_column s_text_byte
//  m_      | m_valid / m_ready   | m_status m_strobe_res m_reg_select m_bus_byte
//          |                     | m_busy_res
//
// One request per cycle sustained while the m_ stage is not held; each result passes
// through the input register, then the result register, after its request is taken.
// Queue and pacing state update once per request in the engine, between the two.
// aresetn (synchronous) empties the queue, closes any open request, zeroes the tick.
// A held m_ stage stops the engine; s_ready drops while the input register is full and held.
module char_lcd_paced_write_queue_unit #(
    parameter int QUEUE_DEPTH = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_tick_value,
    input  logic [1:0]  s_row,
    input  logic [5:0]  s_column,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_strobe_res,
    output logic        m_reg_select,
    output logic [7:0]  m_bus_byte,
    output logic        m_busy_res
);

    lcdq_pkg::item_t   s_item;
    lcdq_pkg::item_t   hold_item;
    lcdq_pkg::result_t eng_res;
    lcdq_pkg::result_t m_res;
    logic              hold_valid;
    logic              can_load;
    logic              fire;

    assign s_item = '{cmd: s_cmd, tick_value: s_tick_value, row: s_row,
                      column: s_column, text_byte: s_text_byte};
    assign fire   = hold_valid && can_load;

    lcdq_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (s_item),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .take       (fire)
    );

    lcdq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (hold_item),
        .res     (eng_res)
    );

    lcdq_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .load_res  (eng_res),
        .can_load  (can_load),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (m_res)
    );

    assign m_status     = m_res.status;
    assign m_strobe_res = m_res.strobe_res;
    assign m_reg_select = m_res.reg_select;
    assign m_bus_byte   = m_res.bus_byte;
    assign m_busy_res   = m_res.busy_res;

endmodule

// ===== hw/rtl/lcdq_checker.sv =====
// Port-level checks of the LCD write queue, bound to the top level.
// Depends on assert_macros.svh and char_lcd_paced_write_queue_unit.
`include "assert_macros.svh"

module lcdq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_status,
    input logic       m_strobe_res,
    input logic       m_reg_select,
    input logic [7:0] m_bus_byte,
    input logic       m_busy_res
);

    logic [11:0] m_payload;

    assign m_payload = {m_status, m_strobe_res, m_reg_select, m_bus_byte, m_busy_res};

    // a held result keeps its payload
    `LCDQ_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload))
    // an issued panel write always comes from an accepted step
    `LCDQ_ASSERT(a_strobe_ok, aclk, aresetn, m_valid && m_strobe_res |-> !m_status)
    // with no write issued the bus fields read zero
    `LCDQ_ASSERT(a_idle_bus, aclk, aresetn, m_valid && !m_strobe_res |-> !m_reg_select && m_bus_byte == 8'd0)
    // nothing is reported right after reset
    `LCDQ_ASSERT_ALWAYS(a_rst_quiet, aclk, !aresetn |=> !m_valid)
    // the input side is open right after reset
    `LCDQ_ASSERT_ALWAYS(a_rst_ready, aclk, !aresetn |=> s_ready)

endmodule

bind char_lcd_paced_write_queue_unit lcdq_checker u_lcdq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_strobe_res (m_strobe_res),
    .m_reg_select (m_reg_select),
    .m_bus_byte   (m_bus_byte),
    .m_busy_res   (m_busy_res)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for char_lcd_paced_write_queue_unit: directed rows, then random requests.
// Depends on lcdq_pkg and the RTL of the unit; predicts results with its own queue model or a row's table value.
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DEPTH       = 24;
    localparam int TARGET_REQS = 900;
    localparam int IDLE_LIMIT  = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = lcdq_pkg::CMD_TICK;
    logic [15:0] s_tick_value = '0;
    logic [1:0]  s_row = '0;
    logic [5:0]  s_column = '0;
    logic [7:0]  s_text_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic        m_strobe_res;
    logic        m_reg_select;
    logic [7:0]  m_bus_byte;
    logic        m_busy_res;

    always #2 aclk = ~aclk;

    char_lcd_paced_write_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_tick_value (s_tick_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_strobe_res (m_strobe_res),
        .m_reg_select (m_reg_select),
        .m_bus_byte   (m_bus_byte),
        .m_busy_res   (m_busy_res)
    );

    // write queue model state
    logic        q_kind [DEPTH];
    logic [7:0]  q_byte [DEPTH];
    logic [4:0]  q_fill = '0;
    logic [4:0]  q_sendpos = '0;
    logic [15:0] q_next_tick = '0;
    logic        q_open = 1'b0;

    lcdq_pkg::result_t pending_results [$];
    int err_count = 0;
    int res_count = 0;
    int write_count = 0;
    int req_count = 0;
    int good_reqs = 0;
    int burst_left = 0;
    int rx_cycle = 0;
    int rx_hold = 0;

    typedef struct {
        lcdq_pkg::item_t   req;
        int                reps;
        bit                typed;
        lcdq_pkg::result_t want;
    } stim_row_t;

    stim_row_t stim_rows [$];

    function automatic lcdq_pkg::result_t lcd_queue_step(input lcdq_pkg::item_t it);
        lcdq_pkg::result_t r;
        logic [15:0] lead;
        logic [7:0]  addr;
        r = '0;
        case (it.cmd)
            lcdq_pkg::CMD_TICK: begin
                q_open = 1'b0;
                if (q_sendpos < q_fill) begin
                    lead = it.tick_value - q_next_tick;
                    // pacing: send only when the signed 16-bit lead is not negative
                    if (!lead[15]) begin
                        r.strobe_res = 1'b1;
                        r.reg_select = q_kind[q_sendpos];
                        r.bus_byte   = q_byte[q_sendpos];
                        q_sendpos    = q_sendpos + 5'd1;
                        q_next_tick  = it.tick_value + 16'd1;
                        if (q_sendpos >= q_fill) begin
                            q_fill    = '0;
                            q_sendpos = '0;
                        end
                    end
                end
            end
            lcdq_pkg::CMD_START: begin
                if (!((it.row == lcdq_pkg::ROW_FIRST || it.row == lcdq_pkg::ROW_SECOND) &&
                      it.column >= 6'd1 && it.column <= lcdq_pkg::MAX_COLUMN)) begin
                    r.status = 1'b1;
                end else if (q_fill != 0) begin
                    r.status = 1'b1;
                end else begin
                    addr = lcdq_pkg::ADDR_BASE + {2'b00, it.column} - 8'd1;
                    if (it.row == lcdq_pkg::ROW_SECOND) begin
                        addr = addr + lcdq_pkg::ROW2_OFFSET;
                    end
                    q_kind[0] = lcdq_pkg::KIND_COMMAND;
                    q_byte[0] = addr;
                    q_fill    = 5'd1;
                    q_sendpos = '0;
                    q_open    = 1'b1;
                end
            end
            lcdq_pkg::CMD_TEXT: begin
                if (!q_open) begin
                    r.status = 1'b1;
                end else if (it.text_byte == 8'd0) begin
                    q_open = 1'b0;
                end else if (q_fill >= DEPTH) begin
                    r.status = 1'b1;
                    q_open   = 1'b0;
                end else begin
                    q_kind[q_fill] = lcdq_pkg::KIND_DATA;
                    q_byte[q_fill] = it.text_byte;
                    q_fill         = q_fill + 5'd1;
                end
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.busy_res = (q_fill != 0);
        return r;
    endfunction

    function automatic lcdq_pkg::item_t rand_item(input logic [1:0] c);
        lcdq_pkg::item_t it;
        it.cmd        = c;
        it.tick_value = 16'($urandom_range(0, 65535));
        it.row        = 2'($urandom_range(0, 3));
        it.column     = 6'($urandom_range(0, 63));
        it.text_byte  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic lcdq_pkg::item_t start_item();
        lcdq_pkg::item_t it;
        it        = rand_item(lcdq_pkg::CMD_START);
        it.row    = ($urandom_range(0, 1) != 0) ? lcdq_pkg::ROW_SECOND : lcdq_pkg::ROW_FIRST;
        it.column = 6'($urandom_range(1, 40));
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t result %0d: %s", $time, res_count, what);
        err_count++;
    endtask

    task automatic add_row(input logic [1:0] c, input logic [15:0] tk, input logic [1:0] rw,
                           input logic [5:0] cl, input logic [7:0] txt, input int reps,
                           input int typed, input logic st, input logic busy);
        stim_row_t e;
        e.req.cmd         = c;
        e.req.tick_value  = tk;
        e.req.row         = rw;
        e.req.column      = cl;
        e.req.text_byte   = txt;
        e.reps            = reps;
        e.typed           = (typed != 0);
        e.want            = '0;
        e.want.status     = st;
        e.want.busy_res   = busy;
        stim_rows.push_back(e);
    endtask

    // Drive one request, hold it until taken, then log its predicted result.
    task automatic send_request(input lcdq_pkg::item_t it, input bit use_typed,
                                input lcdq_pkg::result_t typed);
        lcdq_pkg::result_t r;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_cmd        <= it.cmd;
        s_tick_value <= it.tick_value;
        s_row        <= it.row;
        s_column     <= it.column;
        s_text_byte  <= it.text_byte;
        do @(posedge aclk); while (s_ready !== 1'b1);
        r = lcd_queue_step(it);
        pending_results.push_back(use_typed ? typed : r);
        req_count++;
        if (r.status == 1'b0) begin
            good_reqs++;
        end
    endtask

    task automatic send(input lcdq_pkg::item_t it);
        send_request(it, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Tick until the model queue is empty; some ticks land early or far ahead.
    task automatic drain_queue();
        lcdq_pkg::item_t it;
        while (q_fill != 0) begin
            it = rand_item(lcdq_pkg::CMD_TICK);
            case ($urandom_range(0, 9))
                0: it.tick_value = q_next_tick - 16'($urandom_range(1, 4));
                1: it.tick_value = q_next_tick - 16'($urandom_range(1, 32768));
                2: it.tick_value = q_next_tick + 16'($urandom_range(0, 32767));
                default: it.tick_value = q_next_tick + 16'($urandom_range(0, 3));
            endcase
            send(it);
        end
    endtask

    always @(posedge aclk) begin : result_check
        lcdq_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %b, want %b", m_status, want.status));
                if (m_strobe_res !== want.strobe_res)
                    report_mismatch($sformatf("strobe %b, want %b", m_strobe_res,
                                              want.strobe_res));
                if (m_reg_select !== want.reg_select)
                    report_mismatch($sformatf("reg_select %b, want %b", m_reg_select,
                                              want.reg_select));
                if (m_bus_byte !== want.bus_byte)
                    report_mismatch($sformatf("bus_byte %h, want %h", m_bus_byte,
                                              want.bus_byte));
                if (m_busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy %b, want %b", m_busy_res, want.busy_res));
            end
            if (m_strobe_res === 1'b1) begin
                write_count++;
            end
            res_count++;
        end
    end

    // Receiver: rotates through always-ready, random, fixed-duty and long-stall modes.
    always @(posedge aclk) begin
        rx_cycle++;
        case ((rx_cycle / 150) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 2) != 0);
            2: m_ready <= ((rx_cycle % 5) < 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        lcdq_pkg::item_t it;
        int    next_pause;
        int    n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty after reset, rejected positions and codes
        add_row(lcdq_pkg::CMD_TICK, 16'h0000, 2'd0, 6'd0, 8'h00, 1, 1, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h41, 1, 1, 1'b1, 1'b0);
        add_row(lcdq_pkg::CMD_START, 16'h0000, 2'd0, 6'd1, 8'h00, 1, 1, 1'b1, 1'b0);
        add_row(lcdq_pkg::CMD_START, 16'h0000, 2'd3, 6'd40, 8'h00, 1, 1, 1'b1, 1'b0);
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_FIRST, 6'd0, 8'h00, 1, 1,
                1'b1, 1'b0);
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_FIRST, 6'd41, 8'h00, 1, 1,
                1'b1, 1'b0);
        add_row(lcdq_pkg::CMD_START, 16'hFFFF, lcdq_pkg::ROW_SECOND, 6'd63, 8'hFF, 1, 1,
                1'b1, 1'b0);
        add_row(CMD_UNUSED, 16'hFFFF, 2'd3, 6'd63, 8'hFF, 1, 1, 1'b1, 1'b0);
        // open a request, reject a second start, close with a zero byte
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_FIRST, 6'd1, 8'h00, 1, 1,
                1'b0, 1'b1);
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_SECOND, 6'd40, 8'h00, 1, 1,
                1'b1, 1'b1);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'hFF, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h01, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h41, 1, 1, 1'b1, 1'b1);
        // pacing around the signed wrap of the tick difference
        add_row(lcdq_pkg::CMD_TICK, 16'hFFFF, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TICK, 16'h0000, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TICK, 16'h0000, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TICK, 16'h8000, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TICK, 16'h8001, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        // a tick closes an open request
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_FIRST, 6'd40, 8'h00, 1, 1,
                1'b0, 1'b1);
        add_row(lcdq_pkg::CMD_TICK, 16'h8002, 2'd0, 6'd0, 8'h00, 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h41, 1, 1, 1'b1, 1'b0);
        // fill the queue, overflow, then text with the request closed
        add_row(lcdq_pkg::CMD_START, 16'h0000, lcdq_pkg::ROW_SECOND, 6'd40, 8'h00, 1, 1,
                1'b0, 1'b1);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h5A, DEPTH - 1, 0, 1'b0, 1'b0);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h33, 1, 1, 1'b1, 1'b1);
        add_row(lcdq_pkg::CMD_TEXT, 16'h0000, 2'd0, 6'd0, 8'h00, 1, 1, 1'b1, 1'b1);

        foreach (stim_rows[i]) begin
            repeat (stim_rows[i].reps) begin
                send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
            end
        end
        wait_drained();

        next_pause = req_count + $urandom_range(100, 250);
        while (req_count < TARGET_REQS) begin
            if (req_count >= next_pause) begin
                wait_drained();
                next_pause = req_count + $urandom_range(100, 250);
            end
            n = $urandom_range(0, 99);
            if (n < 60) begin
                // well-formed request: start, text, optional terminator, paced drain
                drain_queue();
                send(start_item());
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 26) : $urandom_range(0, 8);
                repeat (n) begin
                    it = rand_item(lcdq_pkg::CMD_TEXT);
                    it.text_byte = 8'($urandom_range(1, 255));
                    send(it);
                end
                if ($urandom_range(0, 1) != 0) begin
                    it = rand_item(lcdq_pkg::CMD_TEXT);
                    it.text_byte = 8'h00;
                    send(it);
                end
                drain_queue();
            end else if (n < 80) begin
                send(rand_item(2'($urandom_range(0, 3))));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        it = rand_item(lcdq_pkg::CMD_START);
                        case ($urandom_range(0, 2))
                            0: it.row = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
                            1: it.column = 6'd0;
                            default: it.column = 6'($urandom_range(41, 63));
                        endcase
                        send(it);
                    end
                    1: begin
                        send(rand_item(lcdq_pkg::CMD_TICK));
                        send(rand_item(lcdq_pkg::CMD_TEXT));
                    end
                    2: begin
                        if (q_fill == 0) begin
                            send(start_item());
                        end
                        send(start_item());
                    end
                    default: begin
                        if (q_fill == 0) begin
                            send(start_item());
                        end
                        repeat ($urandom_range(1, 4)) send(rand_item(lcdq_pkg::CMD_TEXT));
                        send(rand_item(lcdq_pkg::CMD_TICK));
                        repeat ($urandom_range(1, 2)) send(rand_item(lcdq_pkg::CMD_TEXT));
                    end
                endcase
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("sent %0d requests (%0d accepted), checked %0d results", req_count, good_reqs,
                 res_count);
        $display("queue paths exercised: %0d panel writes issued, %0d mismatches", write_count,
                 err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
